// ----- hw/rtl/lrpp_pkg.sv -----
// Shared types and constants for the LED row pixel packetizer.
// Holds the register map, the front-to-back queue entry and the header byte positions.
// No dependencies.
`timescale 1ns / 1ps

package lrpp_pkg;

    // Input actions
    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_PIXEL = 1'b1;

    // Gamma table
    localparam int GAMMA_ENTRIES = 256;
    localparam int GAMMA_AW      = $clog2(GAMMA_ENTRIES);

    // Configuration port
    localparam int REG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_PIXEL_ORDER  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_CHUNK_LIMIT  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_PACKET_KIND  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_TARGET_ADDR  = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_SENDER_ADDR  = 3'd6;

    // Colour orders
    localparam logic [2:0] ORDER_RGB = 3'd0;
    localparam logic [2:0] ORDER_BGR = 3'd1;
    localparam logic [2:0] ORDER_GRB = 3'd2;
    localparam logic [2:0] ORDER_GBR = 3'd3;
    localparam logic [2:0] ORDER_RBG = 3'd4;
    localparam logic [2:0] ORDER_BRG = 3'd5;

    // Byte positions within the bytes of one pixel (header then colours)
    localparam int POS_W = 5;
    localparam logic [POS_W-1:0] POS_DST      = 5'd0;
    localparam logic [POS_W-1:0] POS_SRC      = 5'd6;
    localparam logic [POS_W-1:0] POS_TYPE_HI  = 5'd12;
    localparam logic [POS_W-1:0] POS_TYPE_LO  = 5'd13;
    localparam logic [POS_W-1:0] POS_ROW_LO   = 5'd14;
    localparam logic [POS_W-1:0] POS_OFS_HI   = 5'd15;
    localparam logic [POS_W-1:0] POS_OFS_LO   = 5'd16;
    localparam logic [POS_W-1:0] POS_CNT_HI   = 5'd17;
    localparam logic [POS_W-1:0] POS_CNT_LO   = 5'd18;
    localparam logic [POS_W-1:0] POS_TAIL_A   = 5'd19;
    localparam logic [POS_W-1:0] POS_TAIL_B   = 5'd20;
    localparam logic [POS_W-1:0] POS_COLOUR0  = 5'd21;
    localparam logic [POS_W-1:0] POS_COLOUR1  = 5'd22;
    localparam logic [POS_W-1:0] POS_COLOUR2  = 5'd23;

    localparam logic [7:0] HDR_TAIL_A = 8'h08;
    localparam logic [7:0] HDR_TAIL_B = 8'h00;
    localparam logic [7:0] BYTE_MASK  = 8'hFF;

    // Front to back queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [15:0] image_width;
        logic [15:0] image_height;
        logic [2:0]  pixel_order;
        logic [8:0]  chunk_limit;
        logic [15:0] pixel_packet_kind;
        logic [47:0] target_address;
        logic [47:0] sender_address;
    } cfg_t;

    typedef struct packed {
        logic        hdr;
        logic [15:0] row;
        logic [15:0] col;
        logic [8:0]  cnt;
        logic        pkt_end;
        logic        frm_end;
    } desc_t;

    typedef struct packed {
        desc_t      desc;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } entry_t;

endpackage

// ----- hw/rtl/lrpp_in_if.sv -----
// Input channel of the packetizer: gamma loads and pixels.
// Valid/ready handshake; no dependencies.
`timescale 1ns / 1ps

interface lrpp_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] gamma_slot;
    logic [7:0] gamma_level;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (output valid, action, gamma_slot, gamma_level, red, green, blue,
                    input ready);
    modport sink   (input valid, action, gamma_slot, gamma_level, red, green, blue,
                    output ready);
    modport mon    (input valid, ready, action, gamma_slot, gamma_level, red, green, blue);
endinterface

// ----- hw/rtl/lrpp_out_if.sv -----
// Output channel of the packetizer: one frame byte per request with end flags.
// Valid/ready handshake; no dependencies.
`timescale 1ns / 1ps

interface lrpp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       packet_end;
    logic       run_end;
    logic       frame_end;

    modport source (output valid, out_byte, packet_end, run_end, frame_end, input ready);
    modport sink   (input valid, out_byte, packet_end, run_end, frame_end, output ready);
    modport mon    (input valid, ready, out_byte, packet_end, run_end, frame_end);
endinterface

// ----- hw/rtl/led_row_pixel_packetizer_top.sv -----
// Top level of the LED row pixel packetizer: configuration registers, front,
// queue and back. Depends on lrpp_pkg, lrpp_in_if, lrpp_out_if and the lrpp modules.
`timescale 1ns / 1ps

// Takes gamma-table loads and raster-order pixels on "items" and sends raw
// Ethernet frame bytes on "frame_bytes", one byte per cycle while the receiver
// is ready. A load is taken at the input and sends nothing; load an entry
// before any pixel uses it. A pixel sends three bytes, or 24 bytes when it
// opens a packet (21 header bytes first); the byte sequencer in the back part
// walks them in order. Input is taken every cycle while the pixel stage or the
// four-entry pixel queue has room, so loads and pixels keep flowing while the
// output stalls. When the block is empty, a taken pixel passes through the
// pixel stage (with the gamma reads) and the queue into the output register,
// where its first byte is offered. Write configuration only while idle.

module led_row_pixel_packetizer_top (
    input  logic                               clk,
    input  logic                               rst_n,
    lrpp_in_if.sink                            items,
    lrpp_out_if.source                         frame_bytes,
    input  logic                               write_enable,
    input  logic [lrpp_pkg::REG_IDX_W-1:0]     register_index,
    input  logic [lrpp_pkg::CFG_DATA_W-1:0]    write_data
);
    import lrpp_pkg::*;

    cfg_t   cfg_reg;
    entry_t push_entry;
    entry_t head;
    logic   push;
    logic   pop;
    logic   queue_full;
    logic   queue_empty;

    // Configuration register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.image_width       <= 16'd128;
            cfg_reg.image_height      <= 16'd64;
            cfg_reg.pixel_order       <= ORDER_RGB;
            cfg_reg.chunk_limit       <= 9'd497;
            cfg_reg.pixel_packet_kind <= 16'd85;
            cfg_reg.target_address    <= 48'd0;
            cfg_reg.sender_address    <= 48'd0;
        end
        else if (write_enable)
        begin
            unique case (register_index)
                REG_IMAGE_WIDTH:  cfg_reg.image_width       <= write_data[15:0];
                REG_IMAGE_HEIGHT: cfg_reg.image_height      <= write_data[15:0];
                REG_PIXEL_ORDER:  cfg_reg.pixel_order       <= write_data[2:0];
                REG_CHUNK_LIMIT:  cfg_reg.chunk_limit       <= write_data[8:0];
                REG_PACKET_KIND:  cfg_reg.pixel_packet_kind <= write_data[15:0];
                REG_TARGET_ADDR:  cfg_reg.target_address    <= write_data[47:0];
                REG_SENDER_ADDR:  cfg_reg.sender_address    <= write_data[47:0];
                default:          cfg_reg <= cfg_reg;
            endcase
        end
    end

    lrpp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .items      (items),
        .cfg        (cfg_reg),
        .push_entry (push_entry),
        .push       (push),
        .queue_full (queue_full)
    );

    lrpp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .empty      (queue_empty),
        .full       (queue_full)
    );

    lrpp_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .head        (head),
        .queue_empty (queue_empty),
        .pop         (pop),
        .frame_bytes (frame_bytes)
    );

endmodule

// ----- hw/rtl/lrpp_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module lrpp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read, held while not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/lrpp_front.sv -----
// Front part: accepts loads and pixels, keeps the row/column/chunk counters and
// classifies each pixel. Depends on lrpp_pkg, lrpp_in_if and lrpp_ram.
`timescale 1ns / 1ps

module lrpp_front (
    input  logic            clk,
    input  logic            rst_n,
    lrpp_in_if.sink         items,
    input  lrpp_pkg::cfg_t  cfg,
    output lrpp_pkg::entry_t push_entry,
    output logic            push,
    input  logic            queue_full
);
    import lrpp_pkg::*;

    logic        accept;
    logic        load_we;
    logic        pix_re;
    logic        stage_valid_reg;
    logic        stage_valid_next;
    desc_t       stage_desc_reg;
    desc_t       desc_now;
    logic [15:0] col_reg, col_next;
    logic [15:0] row_reg, row_next;
    logic [8:0]  left_reg, left_next;
    logic [15:0] w_eff, h_eff;
    logic [8:0]  lim_eff;
    logic        col_wrap;
    logic [15:0] col_a, row_a, rest;
    logic [8:0]  left_a, left_b, left_c, cnt;
    logic [16:0] col_inc, row_inc;
    logic        row_end, frame_wrap;
    logic [7:0]  g_red, g_green, g_blue;

    // Take a request when the stage is free or moves into the queue this cycle
    assign items.ready = !stage_valid_reg || !queue_full;
    assign accept      = items.valid && items.ready;
    assign load_we     = accept && (items.action == ACT_LOAD);
    assign pix_re      = accept && (items.action == ACT_PIXEL);

    // Three copies of the gamma table, one per colour
    lrpp_ram #(.WIDTH(8), .DEPTH(GAMMA_ENTRIES)) u_gamma_r (
        .clk(clk), .we(load_we), .waddr(items.gamma_slot), .wdata(items.gamma_level),
        .re(pix_re), .raddr(items.red), .rdata(g_red));
    lrpp_ram #(.WIDTH(8), .DEPTH(GAMMA_ENTRIES)) u_gamma_g (
        .clk(clk), .we(load_we), .waddr(items.gamma_slot), .wdata(items.gamma_level),
        .re(pix_re), .raddr(items.green), .rdata(g_green));
    lrpp_ram #(.WIDTH(8), .DEPTH(GAMMA_ENTRIES)) u_gamma_b (
        .clk(clk), .we(load_we), .waddr(items.gamma_slot), .wdata(items.gamma_level),
        .re(pix_re), .raddr(items.blue), .rdata(g_blue));

    // Classify the pixel against the current counters
    always_comb
    begin
        w_eff   = (cfg.image_width  == 16'd0) ? 16'd1 : cfg.image_width;
        h_eff   = (cfg.image_height == 16'd0) ? 16'd1 : cfg.image_height;
        lim_eff = (cfg.chunk_limit  == 9'd0)  ? 9'd1  : cfg.chunk_limit;

        col_wrap = (col_reg >= w_eff);
        col_a    = col_wrap ? 16'd0 : col_reg;
        left_a   = col_wrap ? 9'd0  : left_reg;
        row_a    = (row_reg >= h_eff) ? 16'd0 : row_reg;

        rest   = w_eff - col_a;
        cnt    = (rest < {7'd0, lim_eff}) ? rest[8:0] : lim_eff;
        left_b = (left_a == 9'd0) ? cnt : left_a;
        left_c = left_b - 9'd1;

        col_inc    = {1'b0, col_a} + 17'd1;
        row_end    = (col_inc >= {1'b0, w_eff});
        row_inc    = {1'b0, row_a} + 17'd1;
        frame_wrap = row_end && (row_inc >= {1'b0, h_eff});

        desc_now.hdr     = (left_a == 9'd0);
        desc_now.row     = row_a;
        desc_now.col     = col_a;
        desc_now.cnt     = cnt;
        desc_now.pkt_end = (left_c == 9'd0) || row_end;
        desc_now.frm_end = frame_wrap;

        col_next  = row_end ? 16'd0 : col_inc[15:0];
        left_next = row_end ? 9'd0 : left_c;
        if (!row_end)
        begin
            row_next = row_a;
        end
        else if (frame_wrap)
        begin
            row_next = 16'd0;
        end
        else
        begin
            row_next = row_inc[15:0];
        end
    end

    // Advance the counters on each pixel
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= 16'd0;
            row_reg  <= 16'd0;
            left_reg <= 9'd0;
        end
        else if (pix_re)
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            left_reg <= left_next;
        end
    end

    // Hold the classified pixel while the gamma reads complete
    always_comb
    begin
        stage_valid_next = stage_valid_reg && queue_full;
        if (pix_re)
        begin
            stage_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pix_re)
        begin
            stage_desc_reg <= desc_now;
        end
    end

    assign push             = stage_valid_reg && !queue_full;
    assign push_entry.desc  = stage_desc_reg;
    assign push_entry.red   = g_red;
    assign push_entry.green = g_green;
    assign push_entry.blue  = g_blue;

endmodule

// ----- hw/rtl/lrpp_queue.sv -----
// Short queue of classified pixels between the front and back parts.
// Depends on lrpp_pkg.
`timescale 1ns / 1ps

module lrpp_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  lrpp_pkg::entry_t push_entry,
    input  logic             pop,
    output lrpp_pkg::entry_t head,
    output logic             empty,
    output logic             full
);
    import lrpp_pkg::*;

    entry_t              slots [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW:0]   fill_reg;
    logic [QUEUE_AW:0]   fill_next;

    assign empty = (fill_reg == '0);
    assign full  = (fill_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign head  = slots[rd_ptr_reg];

    always_comb
    begin
        fill_next = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + (QUEUE_AW+1)'(1);
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - (QUEUE_AW+1)'(1);
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QUEUE_AW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QUEUE_AW'(1);
            end
        end
    end

    // Store the entry
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ----- hw/rtl/lrpp_back.sv -----
// Back part: byte sequencer that walks the header and colour bytes of each
// queued pixel into the output register. Depends on lrpp_pkg and lrpp_out_if.
`timescale 1ns / 1ps

module lrpp_back (
    input  logic             clk,
    input  logic             rst_n,
    input  lrpp_pkg::cfg_t   cfg,
    input  lrpp_pkg::entry_t head,
    input  logic             queue_empty,
    output logic             pop,
    lrpp_out_if.source       frame_bytes
);
    import lrpp_pkg::*;

    logic             started_reg;
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos;
    logic             emit;
    logic             last;
    logic [7:0]       byte_now;
    logic [7:0]       c0, c1, c2;
    logic             out_valid_reg;
    logic [7:0]       out_byte_reg;
    logic             packet_end_reg;
    logic             run_end_reg;
    logic             frame_end_reg;

    assign pos  = started_reg ? pos_reg : (head.desc.hdr ? POS_DST : POS_COLOUR0);
    assign emit = !queue_empty && (!out_valid_reg || frame_bytes.ready);
    assign last = (pos == POS_COLOUR2);
    assign pop  = emit && last;

    // Colour order select
    always_comb
    begin
        unique case (cfg.pixel_order)
            ORDER_BGR: begin c0 = head.blue;  c1 = head.green; c2 = head.red;   end
            ORDER_GRB: begin c0 = head.green; c1 = head.red;   c2 = head.blue;  end
            ORDER_GBR: begin c0 = head.green; c1 = head.blue;  c2 = head.red;   end
            ORDER_RBG: begin c0 = head.red;   c1 = head.blue;  c2 = head.green; end
            ORDER_BRG: begin c0 = head.blue;  c1 = head.red;   c2 = head.green; end
            default:   begin c0 = head.red;   c1 = head.green; c2 = head.blue;  end
        endcase
    end

    // Select the byte at the current position
    always_comb
    begin
        case (pos)
            POS_DST + 5'd0: byte_now = cfg.target_address[47:40];
            POS_DST + 5'd1: byte_now = cfg.target_address[39:32];
            POS_DST + 5'd2: byte_now = cfg.target_address[31:24];
            POS_DST + 5'd3: byte_now = cfg.target_address[23:16];
            POS_DST + 5'd4: byte_now = cfg.target_address[15:8];
            POS_DST + 5'd5: byte_now = cfg.target_address[7:0];
            POS_SRC + 5'd0: byte_now = cfg.sender_address[47:40];
            POS_SRC + 5'd1: byte_now = cfg.sender_address[39:32];
            POS_SRC + 5'd2: byte_now = cfg.sender_address[31:24];
            POS_SRC + 5'd3: byte_now = cfg.sender_address[23:16];
            POS_SRC + 5'd4: byte_now = cfg.sender_address[15:8];
            POS_SRC + 5'd5: byte_now = cfg.sender_address[7:0];
            POS_TYPE_HI:
            begin
                // Full type word when the kind does not fit a byte
                if (cfg.pixel_packet_kind[15:8] != 8'd0)
                begin
                    byte_now = cfg.pixel_packet_kind[15:8];
                end
                else
                begin
                    byte_now = cfg.pixel_packet_kind[7:0];
                end
            end
            POS_TYPE_LO:
            begin
                if (cfg.pixel_packet_kind[15:8] != 8'd0)
                begin
                    byte_now = cfg.pixel_packet_kind[7:0];
                end
                else
                begin
                    byte_now = head.desc.row[15:8];
                end
            end
            POS_ROW_LO:  byte_now = head.desc.row[7:0];
            POS_OFS_HI:  byte_now = head.desc.col[15:8];
            POS_OFS_LO:  byte_now = head.desc.col[7:0];
            POS_CNT_HI:  byte_now = {7'd0, head.desc.cnt[8]};
            POS_CNT_LO:  byte_now = head.desc.cnt[7:0];
            POS_TAIL_A:  byte_now = HDR_TAIL_A;
            POS_TAIL_B:  byte_now = HDR_TAIL_B;
            POS_COLOUR0: byte_now = c0;
            POS_COLOUR1: byte_now = c1;
            POS_COLOUR2: byte_now = c2;
            default:     byte_now = BYTE_MASK;
        endcase
    end

    // Advance the position within the head entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg <= 1'b0;
            pos_reg     <= POS_DST;
        end
        else if (emit)
        begin
            started_reg <= !last;
            pos_reg     <= pos + 5'd1;
        end
    end

    // Output register: load on emit, drop once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (frame_bytes.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_byte_reg   <= byte_now;
            packet_end_reg <= last && head.desc.pkt_end;
            run_end_reg    <= last;
            frame_end_reg  <= last && head.desc.frm_end;
        end
    end

    assign frame_bytes.valid      = out_valid_reg;
    assign frame_bytes.out_byte   = out_byte_reg;
    assign frame_bytes.packet_end = packet_end_reg;
    assign frame_bytes.run_end    = run_end_reg;
    assign frame_bytes.frame_end  = frame_end_reg;

endmodule

// ----- hw/rtl/lrpp_checker.sv -----
// Port-level checks for the LED row pixel packetizer, bound to the top level.
// Depends on lrpp_pkg, lrpp_in_if and lrpp_out_if.
`timescale 1ns / 1ps

module lrpp_checker (
    input  logic        clk,
    input  logic        rst_n,
    lrpp_in_if.sink     items,
    lrpp_out_if.source  frame_bytes
);
    import lrpp_pkg::*;

    logic seen_pixel_reg;

    // Note whether any pixel has been taken since reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_pixel_reg <= 1'b0;
        end
        else if (items.valid && items.ready && (items.action == ACT_PIXEL))
        begin
            seen_pixel_reg <= 1'b1;
        end
    end

    // No byte before the first pixel
    a_no_byte_without_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        frame_bytes.valid |-> seen_pixel_reg)
        else $error("output byte before any pixel was taken");

    // The frame end closes its packet
    a_frame_closes_packet: assert property (@(posedge clk) disable iff (!rst_n)
        (frame_bytes.valid && frame_bytes.frame_end) |-> frame_bytes.packet_end)
        else $error("frame end without packet end");

    // A packet ends only on the last byte of a pixel
    a_packet_on_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        (frame_bytes.valid && frame_bytes.packet_end) |-> frame_bytes.run_end)
        else $error("packet end away from the last byte of a pixel");

    // A stalled byte holds
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (frame_bytes.valid && !frame_bytes.ready) |=>
            (frame_bytes.valid && $stable(frame_bytes.out_byte)
             && $stable(frame_bytes.run_end)))
        else $error("output byte changed while stalled");

endmodule

bind led_row_pixel_packetizer_top lrpp_checker u_lrpp_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .items       (items),
    .frame_bytes (frame_bytes)
);

// ----- tb/sv/tb_led_row_pixel_packetizer_top.sv -----
// Self-checking testbench for led_row_pixel_packetizer_top: a directed script, then random scenes.
// Predicts every frame byte in-house and checks each one; needs lrpp_pkg, lrpp_in_if, lrpp_out_if
// and the packetizer RTL.
`timescale 1ns / 1ps

module tb_led_row_pixel_packetizer_top;

    import lrpp_pkg::*;

    localparam int CLK_PERIOD       = 20;
    localparam int RANDOM_ITEMS     = 235;
    localparam int SETTLE_CYCLES    = 8;
    localparam int LONG_HOLD_CYCLES = 200;
    localparam int QUIET_LIMIT      = 2000;
    localparam int MAX_REPORTS      = 10;
    localparam int LOAD_PCT         = 20;

    // Colour orders outside the named set fall back to RGB
    localparam logic [2:0] ORDER_SPARE6 = 3'd6;
    localparam logic [2:0] ORDER_SPARE7 = 3'd7;
    // Register index with no register behind it
    localparam logic [REG_IDX_W-1:0] REG_UNUSED = 3'd7;

    typedef struct packed {
        logic [7:0] data;
        logic       pkt_end;
        logic       run_end;
        logic       frm_end;
    } frame_byte_t;

    typedef enum logic [1:0] {
        STEP_CFG,
        STEP_LOAD,
        STEP_PIXEL
    } step_kind_e;

    typedef struct packed {
        step_kind_e                kind;
        logic [REG_IDX_W-1:0]      idx;
        logic [CFG_DATA_W-1:0]     value;
        logic [7:0]                f0;
        logic [7:0]                f1;
        logic [7:0]                f2;
        logic                      typed;
        logic [23:0]               colours;
    } script_step_t;

    logic                  clk;
    logic                  rst_n;
    logic                  write_enable;
    logic [REG_IDX_W-1:0]  register_index;
    logic [CFG_DATA_W-1:0] write_data;

    lrpp_in_if  items_if ();
    lrpp_out_if bytes_if ();

    led_row_pixel_packetizer_top u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .items          (items_if),
        .frame_bytes    (bytes_if),
        .write_enable   (write_enable),
        .register_index (register_index),
        .write_data     (write_data)
    );

    // Predictor state: configuration copy, gamma copy and raster position
    cfg_t        pred_cfg;
    logic [7:0]  gamma_copy [GAMMA_ENTRIES];
    bit          slot_loaded [GAMMA_ENTRIES];
    logic [7:0]  loaded_slots [$];
    int          column_pos;
    int          row_pos;
    logic [8:0]  chunk_left;

    frame_byte_t  pending_bytes [$];
    script_step_t script [$];

    int mismatch_count;
    int bytes_seen;
    int quiet_cycles;
    int random_items;
    int src_idle_pct;
    int sink_idle_pct;
    bit long_hold_req;
    bit block_busy;

    initial clk = 1'b0;
    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    task automatic push_byte(input logic [7:0] d);
        pending_bytes.push_back({d, 1'b0, 1'b0, 1'b0});
    endtask

    task automatic push_addr(input logic [47:0] a);
        int i;
        for (i = 5; i >= 0; i--)
            push_byte(a[8*i +: 8]);
    endtask

    task automatic build_pixel_bytes(input logic [7:0] r, input logic [7:0] g,
                                     input logic [7:0] b, input bit typed,
                                     input logic [23:0] colours);
        int         w;
        int         h;
        int         lim;
        int         rest;
        int         cnt;
        logic [7:0] gr;
        logic [7:0] gg;
        logic [7:0] gb;
        logic [7:0] c0;
        logic [7:0] c1;
        logic [7:0] c2;
        logic       pkt_end;
        logic       frm_end;

        // Zero sizes count as one
        w   = (pred_cfg.image_width == 0) ? 1 : int'(pred_cfg.image_width);
        h   = (pred_cfg.image_height == 0) ? 1 : int'(pred_cfg.image_height);
        lim = (pred_cfg.chunk_limit == 0) ? 1 : int'(pred_cfg.chunk_limit);

        // Restart the column after the width shrank, and the row after the height did
        if (column_pos >= w)
        begin
            column_pos = 0;
            chunk_left = '0;
        end
        if (row_pos >= h)
            row_pos = 0;

        // Open a packet with its header
        if (chunk_left == 0)
        begin
            rest = w - column_pos;
            cnt = (rest < lim) ? rest : lim;
            chunk_left = cnt[8:0];
            push_addr(pred_cfg.target_address);
            push_addr(pred_cfg.sender_address);
            if (pred_cfg.pixel_packet_kind > 16'h00FF)
            begin
                push_byte(pred_cfg.pixel_packet_kind[15:8]);
                push_byte(pred_cfg.pixel_packet_kind[7:0]);
            end
            else
            begin
                push_byte(pred_cfg.pixel_packet_kind[7:0]);
                push_byte(row_pos[15:8]);
            end
            push_byte(row_pos[7:0]);
            push_byte(column_pos[15:8]);
            push_byte(column_pos[7:0]);
            push_byte(cnt[15:8]);
            push_byte(cnt[7:0]);
            push_byte(HDR_TAIL_A);
            push_byte(HDR_TAIL_B);
        end

        // Correct and reorder the colours
        gr = gamma_copy[r];
        gg = gamma_copy[g];
        gb = gamma_copy[b];
        case (pred_cfg.pixel_order)
            ORDER_BGR: begin c0 = gb; c1 = gg; c2 = gr; end
            ORDER_GRB: begin c0 = gg; c1 = gr; c2 = gb; end
            ORDER_GBR: begin c0 = gg; c1 = gb; c2 = gr; end
            ORDER_RBG: begin c0 = gr; c1 = gb; c2 = gg; end
            ORDER_BRG: begin c0 = gb; c1 = gr; c2 = gg; end
            default:   begin c0 = gr; c1 = gg; c2 = gb; end
        endcase
        if (typed)
            {c0, c1, c2} = colours;
        push_byte(c0);
        push_byte(c1);

        // Advance the raster position; the row end always closes the packet
        chunk_left = chunk_left - 9'd1;
        pkt_end = (chunk_left == 0);
        frm_end = 1'b0;
        column_pos++;
        if (column_pos >= w)
        begin
            column_pos = 0;
            chunk_left = '0;
            pkt_end = 1'b1;
            row_pos++;
            if (row_pos >= h)
            begin
                row_pos = 0;
                frm_end = 1'b1;
            end
        end
        pending_bytes.push_back({c2, pkt_end, 1'b1, frm_end});
    endtask

    // ------------------------------------------------------------------
    // Directed script rows
    // ------------------------------------------------------------------
    function automatic script_step_t cfg_step(input logic [REG_IDX_W-1:0] idx,
                                              input logic [CFG_DATA_W-1:0] value);
        script_step_t s;
        s = '0;
        s.kind = STEP_CFG;
        s.idx = idx;
        s.value = value;
        return s;
    endfunction

    function automatic script_step_t load_step(input logic [7:0] slot, input logic [7:0] level);
        script_step_t s;
        s = '0;
        s.kind = STEP_LOAD;
        s.f0 = slot;
        s.f1 = level;
        return s;
    endfunction

    function automatic script_step_t typed_pixel(input logic [7:0] r, input logic [7:0] g,
                                                 input logic [7:0] b, input logic [23:0] colours);
        script_step_t s;
        s = '0;
        s.kind = STEP_PIXEL;
        s.f0 = r;
        s.f1 = g;
        s.f2 = b;
        s.typed = 1'b1;
        s.colours = colours;
        return s;
    endfunction

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------
    // Offer one request, idling first at random, and predict it once taken
    task automatic offer(input logic act, input logic [7:0] slot, input logic [7:0] level,
                         input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                         input bit typed, input logic [23:0] colours);
        while ($urandom_range(99) < src_idle_pct)
        begin
            items_if.valid <= 1'b0;
            @(posedge clk);
        end
        items_if.valid       <= 1'b1;
        items_if.action      <= act;
        items_if.gamma_slot  <= slot;
        items_if.gamma_level <= level;
        items_if.red         <= r;
        items_if.green       <= g;
        items_if.blue        <= b;
        @(posedge clk);
        while (!items_if.ready)
            @(posedge clk);
        block_busy = 1'b1;
        if (act == ACT_LOAD)
        begin
            gamma_copy[slot] = level;
            if (!slot_loaded[slot])
            begin
                slot_loaded[slot] = 1'b1;
                loaded_slots.push_back(slot);
            end
        end
        else
            build_pixel_bytes(r, g, b, typed, colours);
    endtask

    // Hold the input until every predicted byte has left, then let loads settle
    task automatic wait_for_idle();
        items_if.valid <= 1'b0;
        while (pending_bytes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        block_busy = 1'b0;
    endtask

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        if (block_busy)
            wait_for_idle();
        write_enable   <= 1'b1;
        register_index <= idx;
        write_data     <= value;
        @(posedge clk);
        write_enable <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_IMAGE_WIDTH:  pred_cfg.image_width       = value[15:0];
            REG_IMAGE_HEIGHT: pred_cfg.image_height      = value[15:0];
            REG_PIXEL_ORDER:  pred_cfg.pixel_order       = value[2:0];
            REG_CHUNK_LIMIT:  pred_cfg.chunk_limit       = value[8:0];
            REG_PACKET_KIND:  pred_cfg.pixel_packet_kind = value[15:0];
            REG_TARGET_ADDR:  pred_cfg.target_address    = value[47:0];
            REG_SENDER_ADDR:  pred_cfg.sender_address    = value[47:0];
            default: ;
        endcase
    endtask

    // Mostly small sizes so rows, chunks and frames turn over often
    function automatic logic [CFG_DATA_W-1:0] pick_reg_value(input logic [REG_IDX_W-1:0] idx);
        logic [63:0]           wide;
        logic [CFG_DATA_W-1:0] v;
        wide = {$urandom, $urandom};
        v = '0;
        case (idx)
            REG_IMAGE_WIDTH:
            begin
                case ($urandom_range(9))
                    0:       v = '0;
                    1:       v = 48'hFFFF;
                    2:       v = CFG_DATA_W'($urandom_range(600, 256));
                    default: v = CFG_DATA_W'($urandom_range(6, 1));
                endcase
            end
            REG_IMAGE_HEIGHT:
            begin
                case ($urandom_range(9))
                    0:       v = '0;
                    1:       v = 48'hFFFF;
                    default: v = CFG_DATA_W'($urandom_range(5, 1));
                endcase
            end
            REG_PIXEL_ORDER:
                v = CFG_DATA_W'($urandom_range(7));
            REG_CHUNK_LIMIT:
            begin
                case ($urandom_range(9))
                    0:       v = '0;
                    1:       v = 48'd497;
                    2:       v = CFG_DATA_W'($urandom_range(511, 256));
                    default: v = CFG_DATA_W'($urandom_range(4, 1));
                endcase
            end
            REG_PACKET_KIND:
            begin
                case ($urandom_range(7))
                    1:       v = CFG_DATA_W'($urandom_range(65535, 256));
                    2:       v = '0;
                    3:       v = 48'h00FF;
                    4:       v = 48'h0100;
                    5:       v = 48'hFFFF;
                    default: v = CFG_DATA_W'($urandom_range(255));
                endcase
            end
            default:
            begin
                case ($urandom_range(3))
                    0:       v = '0;
                    1:       v = '1;
                    default: v = wide[47:0];
                endcase
            end
        endcase
        return v;
    endfunction

    // Rewrite some registers, then send a burst of loads and pixels
    task automatic run_scene(input int n_items, input bit hold);
        int         k;
        int         i;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        for (k = 0; k < 7; k++)
            if ($urandom_range(1))
                write_reg(REG_IDX_W'(k), pick_reg_value(REG_IDX_W'(k)));
        if (hold)
            long_hold_req = 1'b1;
        for (i = 0; i < n_items; i++)
        begin
            if ($urandom_range(99) < LOAD_PCT)
                offer(ACT_LOAD, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                      8'($urandom), 1'b0, 24'h0);
            else
            begin
                // Only read gamma entries that were loaded
                r = loaded_slots[$urandom_range(loaded_slots.size() - 1)];
                g = loaded_slots[$urandom_range(loaded_slots.size() - 1)];
                b = loaded_slots[$urandom_range(loaded_slots.size() - 1)];
                offer(ACT_PIXEL, 8'($urandom), 8'($urandom), r, g, b, 1'b0, 24'h0);
            end
        end
        random_items += n_items;
    endtask

    // ------------------------------------------------------------------
    // Receiver side: random stalls, plus one long hold on request
    // ------------------------------------------------------------------
    initial
    begin
        bytes_if.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                bytes_if.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                bytes_if.ready <= ($urandom_range(99) >= sink_idle_pct);
                @(posedge clk);
            end
        end
    end

    // ------------------------------------------------------------------
    // Checker and watchdog
    // ------------------------------------------------------------------
    task automatic check_byte();
        frame_byte_t got;
        frame_byte_t want;
        got = {bytes_if.out_byte, bytes_if.packet_end, bytes_if.run_end, bytes_if.frame_end};
        if (pending_bytes.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("byte %0d: %02h arrived with nothing pending", bytes_seen, got.data);
        end
        else
        begin
            want = pending_bytes.pop_front();
            if (got.data !== want.data || got.pkt_end !== want.pkt_end ||
                got.run_end !== want.run_end || got.frm_end !== want.frm_end)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("byte %0d: expected %02h pkt %b run %b frm %b, got %02h pkt %b run %b frm %b",
                             bytes_seen, want.data, want.pkt_end, want.run_end, want.frm_end,
                             got.data, got.pkt_end, got.run_end, got.frm_end);
            end
        end
        bytes_seen++;
    endtask

    always @(posedge clk)
    begin
        if ((items_if.valid && items_if.ready) || (bytes_if.valid && bytes_if.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
        else if (rst_n && bytes_if.valid && bytes_if.ready)
            check_byte();
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        script_step_t step;
        bit           hold_done;

        // Drive every input to a known value and hold reset
        rst_n                <= 1'b0;
        write_enable         <= 1'b0;
        register_index       <= REG_IMAGE_WIDTH;
        write_data           <= '0;
        items_if.valid       <= 1'b0;
        items_if.action      <= ACT_LOAD;
        items_if.gamma_slot  <= 8'h00;
        items_if.gamma_level <= 8'h00;
        items_if.red         <= 8'h00;
        items_if.green       <= 8'h00;
        items_if.blue        <= 8'h00;

        pred_cfg = '0;
        pred_cfg.image_width       = 16'd128;
        pred_cfg.image_height      = 16'd64;
        pred_cfg.chunk_limit       = 9'd497;
        pred_cfg.pixel_packet_kind = 16'd85;
        column_pos     = 0;
        row_pos        = 0;
        chunk_left     = '0;
        mismatch_count = 0;
        bytes_seen     = 0;
        quiet_cycles   = 0;
        random_items   = 0;
        long_hold_req  = 1'b0;
        block_busy     = 1'b0;
        hold_done      = 1'b0;
        src_idle_pct   = 23;
        sink_idle_pct  = 64;

        // Gamma extremes and two mid patterns; first pixel runs on the reset settings
        script.push_back(load_step(8'h00, 8'hFF));
        script.push_back(load_step(8'hFF, 8'h00));
        script.push_back(load_step(8'h55, 8'hC3));
        script.push_back(load_step(8'hAA, 8'h3C));
        script.push_back(typed_pixel(8'h00, 8'hFF, 8'h55, 24'hFF00C3));
        // Every colour order, the two spare codes reading as RGB
        script.push_back(cfg_step(REG_PIXEL_ORDER, CFG_DATA_W'(ORDER_BGR)));
        script.push_back(typed_pixel(8'h00, 8'hFF, 8'h55, 24'hC300FF));
        script.push_back(cfg_step(REG_PIXEL_ORDER, CFG_DATA_W'(ORDER_GRB)));
        script.push_back(typed_pixel(8'h00, 8'hFF, 8'h55, 24'h00FFC3));
        script.push_back(cfg_step(REG_PIXEL_ORDER, CFG_DATA_W'(ORDER_GBR)));
        script.push_back(typed_pixel(8'h00, 8'hFF, 8'h55, 24'h00C3FF));
        script.push_back(cfg_step(REG_PIXEL_ORDER, CFG_DATA_W'(ORDER_RBG)));
        script.push_back(typed_pixel(8'h00, 8'hFF, 8'h55, 24'hFFC300));
        script.push_back(cfg_step(REG_PIXEL_ORDER, CFG_DATA_W'(ORDER_BRG)));
        script.push_back(typed_pixel(8'h00, 8'hFF, 8'h55, 24'hC3FF00));
        script.push_back(cfg_step(REG_PIXEL_ORDER, CFG_DATA_W'(ORDER_SPARE6)));
        script.push_back(typed_pixel(8'h00, 8'hFF, 8'h55, 24'hFF00C3));
        script.push_back(cfg_step(REG_PIXEL_ORDER, CFG_DATA_W'(ORDER_SPARE7)));
        script.push_back(typed_pixel(8'h00, 8'hFF, 8'h55, 24'hFF00C3));
        // Shrink the width below the column, split the row in two chunks, whole type word
        script.push_back(cfg_step(REG_IMAGE_WIDTH, 48'd3));
        script.push_back(cfg_step(REG_CHUNK_LIMIT, 48'd2));
        script.push_back(cfg_step(REG_PACKET_KIND, 48'h0800));
        script.push_back(cfg_step(REG_TARGET_ADDR, 48'hFFFF_FFFF_FFFF));
        script.push_back(cfg_step(REG_SENDER_ADDR, 48'h0123_4567_89AB));
        script.push_back(cfg_step(REG_UNUSED, 48'hFFFF_FFFF_FFFF));
        script.push_back(typed_pixel(8'hAA, 8'h55, 8'hFF, 24'h3CC300));
        script.push_back(typed_pixel(8'hAA, 8'h55, 8'hFF, 24'h3CC300));
        script.push_back(typed_pixel(8'hAA, 8'h55, 8'hFF, 24'h3CC300));
        // Zero sizes act as one: every pixel closes a frame
        script.push_back(cfg_step(REG_IMAGE_WIDTH, 48'd0));
        script.push_back(cfg_step(REG_IMAGE_HEIGHT, 48'd0));
        script.push_back(cfg_step(REG_CHUNK_LIMIT, 48'd0));
        script.push_back(cfg_step(REG_PACKET_KIND, 48'd0));
        script.push_back(cfg_step(REG_PIXEL_ORDER, CFG_DATA_W'(ORDER_RGB)));
        script.push_back(typed_pixel(8'hFF, 8'hFF, 8'hFF, 24'h000000));
        script.push_back(typed_pixel(8'hFF, 8'hFF, 8'hFF, 24'h000000));
        // Largest sizes and the type boundaries
        script.push_back(cfg_step(REG_IMAGE_WIDTH, 48'hFFFF));
        script.push_back(cfg_step(REG_IMAGE_HEIGHT, 48'hFFFF));
        script.push_back(cfg_step(REG_CHUNK_LIMIT, 48'd497));
        script.push_back(cfg_step(REG_PACKET_KIND, 48'h00FF));
        script.push_back(cfg_step(REG_TARGET_ADDR, 48'h0));
        script.push_back(cfg_step(REG_SENDER_ADDR, 48'hFFFF_FFFF_FFFF));
        script.push_back(typed_pixel(8'h55, 8'hAA, 8'h00, 24'hC33CFF));
        script.push_back(typed_pixel(8'h55, 8'hAA, 8'h00, 24'hC33CFF));
        script.push_back(typed_pixel(8'h55, 8'hAA, 8'h00, 24'hC33CFF));
        script.push_back(cfg_step(REG_PACKET_KIND, 48'h0100));
        script.push_back(typed_pixel(8'h00, 8'h00, 8'h00, 24'hFFFFFF));
        script.push_back(cfg_step(REG_CHUNK_LIMIT, 48'd1));
        script.push_back(cfg_step(REG_PACKET_KIND, 48'hFFFF));
        script.push_back(typed_pixel(8'h55, 8'h55, 8'h55, 24'hC3C3C3));
        script.push_back(typed_pixel(8'h55, 8'h55, 8'h55, 24'hC3C3C3));
        // Reload an entry and read it straight back
        script.push_back(load_step(8'hFF, 8'h7E));
        script.push_back(typed_pixel(8'hFF, 8'h00, 8'hFF, 24'h7EFF7E));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed script
        foreach (script[k])
        begin
            step = script[k];
            case (step.kind)
                STEP_CFG:
                    write_reg(step.idx, step.value);
                STEP_LOAD:
                    offer(ACT_LOAD, step.f0, step.f1, 8'($urandom), 8'($urandom),
                          8'($urandom), 1'b0, 24'h0);
                default:
                    offer(ACT_PIXEL, 8'($urandom), 8'($urandom), step.f0, step.f1, step.f2,
                          step.typed, step.colours);
            endcase
        end

        // Random scenes: sender idles lightly, then receiver does, then neither
        while (random_items < RANDOM_ITEMS)
        begin
            if (random_items < RANDOM_ITEMS / 3)
            begin
                src_idle_pct  = 23;
                sink_idle_pct = 64;
                run_scene($urandom_range(16, 4), 1'b0);
            end
            else if (random_items < 2 * RANDOM_ITEMS / 3)
            begin
                src_idle_pct  = 64;
                sink_idle_pct = 23;
                run_scene($urandom_range(16, 4), 1'b0);
            end
            else
            begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
                // Stall the output long enough to back up the queue and the input
                if (!hold_done)
                begin
                    hold_done = 1'b1;
                    if (block_busy)
                        wait_for_idle();
                    run_scene(16, 1'b1);
                end
                else
                    run_scene($urandom_range(16, 4), 1'b0);
            end
        end

        wait_for_idle();
        if (mismatch_count == 0 && pending_bytes.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
